### rtl/core/rfc_pkg.sv
package rfc_pkg;

    // Frame layout constants
    localparam logic [7:0]  HDR_BYTE  = 8'hAC;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [8:0]  MIN_LAST  = 9'd6;    // position of the last byte in a 7-byte frame
    localparam logic [8:0]  PRE_DATA  = 9'd5;    // bytes ahead of the payload
    localparam logic [8:0]  COUNT_MAX = 9'd511;

    // Fixed byte positions in the frame
    localparam logic [8:0] POS_HDR  = 9'd0;
    localparam logic [8:0] POS_SEQ  = 9'd1;
    localparam logic [8:0] POS_ADDR = 9'd2;
    localparam logic [8:0] POS_CMD  = 9'd3;
    localparam logic [8:0] POS_LEN  = 9'd4;

    localparam int OUT_DATA_W = 48;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_SEQ_ERR = 2'd2,
        ST_CRC_ERR = 2'd3
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        status_t    frame_status;
        logic [7:0] reply_address;
        logic [7:0] reply_command;
        logic [7:0] reply_length;
    } result_t;

    // One byte into a CRC-16/MODBUS register, LSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### rtl/core/rfc_in_reg.sv
module rfc_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       advance,
    output logic       hold_valid,
    output logic [7:0] hold_byte,
    output logic       hold_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    // Take a new transfer when empty or when the held byte moves on
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
            valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hold the payload until it is consumed
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;
    assign hold_last  = last_reg;

endmodule

### rtl/core/rfc_frame_check.sv
module rfc_frame_check (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             item_valid,
    input  logic [7:0]       rx_byte,
    input  logic             final_byte,
    output logic             has_result,
    output rfc_pkg::result_t result
);

    logic [8:0]  count_reg,   count_next;
    logic [15:0] crc_reg,     crc_next;
    logic [7:0]  d0_reg,      d0_next;
    logic [7:0]  d1_reg,      d1_next;
    logic        hdr_reg,     hdr_next;
    logic        seq_reg,     seq_next;
    logic [7:0]  len_reg,     len_next;
    logic [7:0]  addr_reg,    addr_next;
    logic [7:0]  cmd_reg,     cmd_next;
    logic [7:0]  exp_seq_reg, exp_seq_next;

    logic [15:0]      crc_upd;
    logic [7:0]       addr_cap;
    logic [7:0]       cmd_cap;
    logic [7:0]       len_cap;
    logic [8:0]       data_off;
    logic             in_payload;
    rfc_pkg::status_t status;

    // Fold in the byte two behind; the last two are the received CRC
    assign crc_upd = (count_reg >= 9'd2) ? rfc_pkg::crc_feed(crc_reg, d1_reg) : crc_reg;

    // Header fields including a capture made by this very byte
    assign addr_cap = (count_reg == rfc_pkg::POS_ADDR) ? rx_byte : addr_reg;
    assign cmd_cap  = (count_reg == rfc_pkg::POS_CMD)  ? rx_byte : cmd_reg;
    assign len_cap  = (count_reg == rfc_pkg::POS_LEN)  ? rx_byte : len_reg;

    assign data_off   = count_reg - rfc_pkg::PRE_DATA;
    assign in_payload = (count_reg >= rfc_pkg::PRE_DATA) && (data_off < {1'b0, len_reg});

    // Status checks in priority order
    always_comb
    begin
        if (count_reg < rfc_pkg::MIN_LAST || !hdr_reg)
            status = rfc_pkg::ST_INVALID;
        else if (!seq_reg)
            status = rfc_pkg::ST_SEQ_ERR;
        else if (count_reg != {1'b0, len_reg} + rfc_pkg::MIN_LAST)
            status = rfc_pkg::ST_INVALID;
        else if ({rx_byte, d0_reg} != crc_upd)
            status = rfc_pkg::ST_CRC_ERR;
        else
            status = rfc_pkg::ST_OK;
    end

    // Build the result item
    always_comb
    begin
        result     = '0;
        has_result = 1'b0;
        if (item_valid && final_byte)
        begin
            has_result           = 1'b1;
            result.kind          = rfc_pkg::KIND_STATUS;
            result.frame_status  = status;
            result.reply_address = addr_cap;
            result.reply_command = cmd_cap;
            result.reply_length  = len_cap;
        end
        else if (item_valid && in_payload)
        begin
            has_result           = 1'b1;
            result.kind          = rfc_pkg::KIND_PAYLOAD;
            result.payload_byte  = rx_byte;
            result.payload_index = data_off[7:0];
        end
    end

    // Advance frame state by one byte
    always_comb
    begin
        count_next   = count_reg;
        crc_next     = crc_reg;
        d0_next      = d0_reg;
        d1_next      = d1_reg;
        hdr_next     = hdr_reg;
        seq_next     = seq_reg;
        len_next     = len_reg;
        addr_next    = addr_reg;
        cmd_next     = cmd_reg;
        exp_seq_next = exp_seq_reg;
        if (step)
        begin
            if (final_byte)
            begin
                count_next = '0;
                crc_next   = rfc_pkg::CRC_INIT;
                d0_next    = '0;
                d1_next    = '0;
                hdr_next   = 1'b0;
                seq_next   = 1'b0;
                len_next   = '0;
                addr_next  = '0;
                cmd_next   = '0;
                if (status == rfc_pkg::ST_OK)
                    exp_seq_next = exp_seq_reg + 8'd1;
            end
            else
            begin
                crc_next  = crc_upd;
                d1_next   = d0_reg;
                d0_next   = rx_byte;
                addr_next = addr_cap;
                cmd_next  = cmd_cap;
                len_next  = len_cap;
                if (count_reg == rfc_pkg::POS_HDR)
                    hdr_next = (rx_byte == rfc_pkg::HDR_BYTE);
                if (count_reg == rfc_pkg::POS_SEQ)
                    seq_next = (rx_byte == exp_seq_reg);
                if (count_reg != rfc_pkg::COUNT_MAX)
                    count_next = count_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            crc_reg     <= rfc_pkg::CRC_INIT;
            d0_reg      <= '0;
            d1_reg      <= '0;
            hdr_reg     <= 1'b0;
            seq_reg     <= 1'b0;
            len_reg     <= '0;
            addr_reg    <= '0;
            cmd_reg     <= '0;
            exp_seq_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            d0_reg      <= d0_next;
            d1_reg      <= d1_next;
            hdr_reg     <= hdr_next;
            seq_reg     <= seq_next;
            len_reg     <= len_next;
            addr_reg    <= addr_next;
            cmd_reg     <= cmd_next;
            exp_seq_reg <= exp_seq_next;
        end
    end

endmodule

### rtl/core/reply_frame_checker_crc16_top.sv
// Channel   Dir  Bits          Fields
// s_axis    in   tdata[7:0]    rx_byte
//                tlast         final_byte
// m_axis    out  tuser[0]      result_kind
//                tdata[47:0]   payload_byte, payload_index, frame_status,
//                              reply_address, reply_command, reply_length
//
// One byte per cycle sustained while the output is not stalled: a byte is held
// in the input register, then a byte-wide CRC update and the frame checks land
// any result it makes in the output register.
// Reset clears frame state, the expected sequence number and both valid flags.
// A stalled output holds only bytes that make a result; other bytes pass freely.
module reply_frame_checker_crc16_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // rx_byte
    input  logic                           s_axis_tlast,   // final_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [rfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // payload_byte, payload_index,
                                                           // frame_status, reply_address,
                                                           // reply_command, reply_length, pad
    output logic                           m_axis_tuser    // result_kind
);

    logic             hold_valid;
    logic [7:0]       hold_byte;
    logic             hold_last;
    logic             has_result;
    logic             advance;
    rfc_pkg::result_t result;

    logic             out_valid_reg;
    logic             out_valid_next;
    rfc_pkg::result_t out_reg;

    // Held byte moves on unless its result would overwrite a stalled one
    assign advance = hold_valid && (!has_result || !out_valid_reg || m_axis_tready);

    rfc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte),
        .hold_last  (hold_last)
    );

    rfc_frame_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .item_valid (hold_valid),
        .rx_byte    (hold_byte),
        .final_byte (hold_last),
        .has_result (has_result),
        .result     (result)
    );

    // Output register valid: load on a new result, drop on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && has_result)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {6'd0,
                            out_reg.reply_length,
                            out_reg.reply_command,
                            out_reg.reply_address,
                            out_reg.frame_status,
                            out_reg.payload_index,
                            out_reg.payload_byte};

endmodule
